// ===== rtl/core/btlpm_pkg.sv =====
`default_nettype none

package btlpm_pkg;

    localparam int NODES     = 1024;
    localparam int ADDR_BITS = 32;
    localparam int PORT_BITS = 16;

    localparam int NODE_W  = $clog2(NODES);
    localparam int FREE_W  = $clog2(NODES + 1);
    localparam int LEVEL_W = $clog2(ADDR_BITS + 1);

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_SEARCH = 2'd2,
        K_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_INIT = 2'd0,
        S_IDLE = 2'd1,
        S_WALK = 2'd2,
        S_SPARE = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [15:0] port_value;
    } in_t;

    typedef struct packed {
        logic [15:0] found_port;
        logic        found;
        status_t     status;
    } out_t;

    typedef struct packed {
        logic [NODE_W-1:0]    left;
        logic [NODE_W-1:0]    right;
        logic [PORT_BITS-1:0] port;
        logic                 valid;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef struct packed {
        logic init_root;
        logic load;
        logic walk;
    } cmd_t;

    typedef struct packed {
        logic finish;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_trie_longest_prefix_match.sv =====
`default_nettype none
// IPv4 route table held as a binary trie, longest prefix match.
// Request channel: drive request (kind, address, prefix_len, port_value)
// with start high; the item is taken at a rising edge where busy is low.
// Kinds: insert a route, delete a route with all routes below it, search
// an address; kind three does nothing and returns all zeros.
// Result channel: done is high for exactly one cycle with result
// (found_port, found, status); the receiver cannot stall and must take it.
// Timing: the walk reads one trie node per cycle from the node RAM over
// the levels it walks (prefix_len for insert and delete, up to 32
// matching levels for search). done is registered from the last step and
// is high in the first cycle that busy is low, so a new item can be taken
// while done is high.
// Reset: asynchronous, active low. The cycle after reset clears the root
// node in the RAM, busy stays high for that one cycle, and the allocation
// counter restarts, emptying the table. Nodes cut by delete are not reused;
// status reports a full node store or a delete on a missing path.
module binary_trie_longest_prefix_match (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire btlpm_pkg::in_t  request,
    output logic                 busy,
    output logic                 done,
    output btlpm_pkg::out_t      result
);

    btlpm_pkg::cmd_t  cmd;
    btlpm_pkg::stat_t stat;

    btlpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    btlpm_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/btlpm_ram.sv =====
`default_nettype none

module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/btlpm_ctrl.sv =====
`default_nettype none

module btlpm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire btlpm_pkg::stat_t   stat,
    output btlpm_pkg::cmd_t         cmd,
    output logic                    busy,
    output logic                    done
);

    btlpm_pkg::ctrl_state_t state_reg, state_next;
    logic done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btlpm_pkg::S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btlpm_pkg::S_INIT:
            begin
                state_next = btlpm_pkg::S_IDLE;
            end
            btlpm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = btlpm_pkg::S_WALK;
                end
            end
            btlpm_pkg::S_WALK:
            begin
                if (stat.finish)
                begin
                    state_next = btlpm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btlpm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.init_root = (state_reg == btlpm_pkg::S_INIT);
        cmd.load      = (state_reg == btlpm_pkg::S_IDLE) && start;
        cmd.walk      = (state_reg == btlpm_pkg::S_WALK);
        busy          = (state_reg != btlpm_pkg::S_IDLE);
        done_next     = (state_reg == btlpm_pkg::S_WALK) && stat.finish;
    end

    assign done = done_reg;

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == btlpm_pkg::S_WALK))
        else $error("strobe without a finished walk");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == btlpm_pkg::S_IDLE)
        else $error("controller not idle after finish");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == btlpm_pkg::S_WALK)
        else $error("load did not start a walk");

endmodule

`default_nettype wire

// ===== rtl/core/btlpm_dpath.sv =====
`default_nettype none

module btlpm_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire btlpm_pkg::cmd_t  cmd,
    input  wire btlpm_pkg::in_t   request,
    output btlpm_pkg::stat_t      stat,
    output btlpm_pkg::out_t       result
);

    localparam int NODE_W  = btlpm_pkg::NODE_W;
    localparam int FREE_W  = btlpm_pkg::FREE_W;
    localparam int LEVEL_W = btlpm_pkg::LEVEL_W;
    localparam int ADDR_BITS = btlpm_pkg::ADDR_BITS;
    localparam int PORT_BITS = btlpm_pkg::PORT_BITS;

    btlpm_pkg::kind_t           kind_reg, kind_next;
    logic [ADDR_BITS-1:0]       addr_reg, addr_next;
    logic [LEVEL_W-1:0]         len_reg, len_next;
    logic [PORT_BITS-1:0]       port_reg, port_next;
    logic [LEVEL_W-1:0]         level_reg, level_next;
    logic [NODE_W-1:0]          cur_reg, cur_next;
    logic                       fresh_reg, fresh_next;
    logic [FREE_W-1:0]          free_reg, free_next;
    logic [PORT_BITS-1:0]       best_port_reg, best_port_next;
    logic                       best_found_reg, best_found_next;
    btlpm_pkg::out_t            result_reg, result_next;

    logic                         rd_en;
    logic [NODE_W-1:0]            rd_addr;
    logic [btlpm_pkg::NODE_BITS-1:0] rd_data;
    logic                         wr_en;
    logic [NODE_W-1:0]            wr_addr;
    btlpm_pkg::node_t             wr_node;

    btlpm_pkg::node_t   eff;
    logic               bit_sel;
    logic [NODE_W-1:0]  child;
    logic               at_len;
    logic               at_top;
    logic               full;
    logic [LEVEL_W-1:0] in_len;

    btlpm_ram #(
        .WIDTH (btlpm_pkg::NODE_BITS),
        .DEPTH (btlpm_pkg::NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= FREE_W'(1);
            fresh_reg <= 1'b0;
        end
        else
        begin
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        port_reg       <= port_next;
        level_reg      <= level_next;
        cur_reg        <= cur_next;
        best_port_reg  <= best_port_next;
        best_found_reg <= best_found_next;
        result_reg     <= result_next;
    end

    always_comb
    begin
        if (request.prefix_len > 6'(ADDR_BITS))
        begin
            in_len = LEVEL_W'(ADDR_BITS);
        end
        else
        begin
            in_len = LEVEL_W'(request.prefix_len);
        end

        eff     = fresh_reg ? '0 : btlpm_pkg::node_t'(rd_data);
        bit_sel = addr_reg[ADDR_BITS-1];
        child   = bit_sel ? eff.right : eff.left;
        at_len  = (level_reg == len_reg);
        at_top  = (level_reg == LEVEL_W'(ADDR_BITS));
        full    = (free_reg >= FREE_W'(btlpm_pkg::NODES));
    end

    always_comb
    begin
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        port_next       = port_reg;
        level_next      = level_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        free_next       = free_reg;
        best_port_next  = best_port_reg;
        best_found_next = best_found_reg;
        result_next     = result_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_node         = eff;
        stat.finish     = 1'b0;

        if (cmd.init_root)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_node = '0;
        end

        if (cmd.load)
        begin
            kind_next       = request.kind;
            addr_next       = request.address[ADDR_BITS-1:0];
            len_next        = in_len;
            port_next       = request.port_value[PORT_BITS-1:0];
            level_next      = '0;
            cur_next        = '0;
            fresh_next      = 1'b0;
            best_port_next  = '0;
            best_found_next = 1'b0;
            rd_en           = 1'b1;
            rd_addr         = '0;
        end

        if (cmd.walk)
        begin
            result_next = '{found_port: '0, found: 1'b0, status: btlpm_pkg::ST_OK};
            unique case (kind_reg)
                btlpm_pkg::K_INSERT:
                begin
                    if (at_len)
                    begin
                        wr_en        = 1'b1;
                        wr_node.port  = port_reg;
                        wr_node.valid = 1'b1;
                        stat.finish  = 1'b1;
                    end
                    else if (child != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = child;
                        cur_next   = child;
                        fresh_next = 1'b0;
                        level_next = level_reg + 1'b1;
                        addr_next  = addr_reg << 1;
                    end
                    else if (full)
                    begin
                        wr_en              = fresh_reg;
                        result_next.status = btlpm_pkg::ST_FULL;
                        stat.finish        = 1'b1;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (bit_sel)
                        begin
                            wr_node.right = NODE_W'(free_reg);
                        end
                        else
                        begin
                            wr_node.left = NODE_W'(free_reg);
                        end
                        cur_next   = NODE_W'(free_reg);
                        free_next  = free_reg + 1'b1;
                        fresh_next = 1'b1;
                        level_next = level_reg + 1'b1;
                        addr_next  = addr_reg << 1;
                    end
                end
                btlpm_pkg::K_DELETE:
                begin
                    if (at_len)
                    begin
                        wr_en       = 1'b1;
                        wr_node     = '0;
                        stat.finish = 1'b1;
                    end
                    else if (child != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = child;
                        cur_next   = child;
                        level_next = level_reg + 1'b1;
                        addr_next  = addr_reg << 1;
                    end
                    else
                    begin
                        result_next.status = btlpm_pkg::ST_NOT_FOUND;
                        stat.finish        = 1'b1;
                    end
                end
                btlpm_pkg::K_SEARCH:
                begin
                    if (eff.valid)
                    begin
                        best_port_next  = eff.port;
                        best_found_next = 1'b1;
                    end
                    if (at_top || child == '0)
                    begin
                        result_next.found_port = 16'(best_port_next);
                        result_next.found      = best_found_next;
                        stat.finish            = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = child;
                        cur_next   = child;
                        level_next = level_reg + 1'b1;
                        addr_next  = addr_reg << 1;
                    end
                end
                default:
                begin
                    stat.finish = 1'b1;
                end
            endcase
        end
    end

    assign result = result_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(btlpm_pkg::NODES))
        else $error("allocation counter past the node store");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("read and write of one node in one cycle");

    a_fresh_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && fresh_reg) |-> kind_reg == btlpm_pkg::K_INSERT)
        else $error("fresh node outside an insert");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> level_reg <= LEVEL_W'(ADDR_BITS))
        else $error("walk deeper than the address");

endmodule

`default_nettype wire
